>>> rtl/core/unlc_pkg.sv
package unlc_pkg;

   // Field widths.
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned LENGTH_WIDTH = 10;
   localparam int unsigned COUNT_WIDTH  = 11;
   localparam int unsigned CODE_WIDTH   = 21;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   // Verdict codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_SHORT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_LONG  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_INVALID   = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LENGTH = 1'd1;

   // Register reset values.
   localparam logic [LENGTH_WIDTH-1:0] MIN_LENGTH_RESET = 10'd1;
   localparam logic [LENGTH_WIDTH-1:0] MAX_LENGTH_RESET = 10'd12;

   // Count saturation limit.
   localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = 11'd1024;

   // Character constants.
   localparam logic [BYTE_WIDTH-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] TAB_CHAR     = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CR_CHAR      = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0] DEL_CHAR     = 8'h7F;
   localparam logic [BYTE_WIDTH-1:0] PIPE_CHAR    = 8'h7C;
   localparam logic [BYTE_WIDTH-1:0] PERCENT_CHAR = 8'h25;

   // Code point limits.
   localparam logic [CODE_WIDTH-1:0] FLOOR_TWO_BYTE   = 21'h80;
   localparam logic [CODE_WIDTH-1:0] FLOOR_THREE_BYTE = 21'h800;
   localparam logic [CODE_WIDTH-1:0] FLOOR_FOUR_BYTE  = 21'h10000;
   localparam logic [CODE_WIDTH-1:0] SURROGATE_LOW    = 21'hD800;
   localparam logic [CODE_WIDTH-1:0] SURROGATE_HIGH   = 21'hDFFF;
   localparam logic [CODE_WIDTH-1:0] C1_LOW           = 21'h80;
   localparam logic [CODE_WIDTH-1:0] C1_HIGH          = 21'h9F;
   localparam logic [CODE_WIDTH-1:0] CODE_MAX         = 21'h10FFFF;

   // Running state of the name being checked.
   typedef struct packed {
      logic                   seen_text;
      logic [COUNT_WIDTH-1:0] pending_spaces;
      logic                   pending_has_control;
      logic [1:0]             bytes_left;
      logic [1:0]             sequence_length;
      logic [CODE_WIDTH-1:0]  code_accumulator;
      logic [COUNT_WIDTH-1:0] point_count;
      logic                   bad_seen;
   } name_state_type;

   // Verdict produced on the final request of a name.
   typedef struct packed {
      logic                    valid;
      logic [STATUS_WIDTH-1:0] status;
      logic [COUNT_WIDTH-1:0]  code_points;
   } verdict_type;

endpackage

>>> rtl/core/utf8_name_length_checker_core.sv
// Checks a display name that arrives one byte per request and reports a
// verdict with the trimmed code point count when the final request arrives.
// Request channel: req_data_byte, req_no_byte (request carries no byte, used to
// end an empty name) and req_last (final request of the name).
// Response channel: one response per request with req_last set, carrying
// rsp_status (ok, too short, too long, invalid) and rsp_code_points.
// Configuration: csr_index 0 writes min_length, 1 writes max_length; writes
// are taken at once and should only be made while no name is in flight.
// Pipeline: a request is captured in the input register, where it is checked
// against the running name state, and its verdict is loaded into the response
// register, which drives rsp_valid. Throughput is one request per cycle while
// the response register is free, set by the combinational byte check against
// the running name state.
// When the receiver stalls, the response register holds and the input
// register fills; after that req_ready drops until a response is taken.
// Reset clears the name state, the pipeline and sets min_length to 1 and
// max_length to 12.
module utf8_name_length_checker_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [unlc_pkg::BYTE_WIDTH-1:0]        req_data_byte,
   input  logic                                   req_no_byte,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [unlc_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [unlc_pkg::COUNT_WIDTH-1:0]       rsp_code_points,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [unlc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [unlc_pkg::LENGTH_WIDTH-1:0]      csr_data
);
   import unlc_pkg::*;

   logic                    in_valid_ff;
   logic [BYTE_WIDTH-1:0]   in_byte_ff;
   logic                    in_no_byte_ff;
   logic                    in_last_ff;
   name_state_type          state_ff;
   name_state_type          state_in;
   verdict_type             verdict;
   logic                    rsp_valid_ff;
   logic [STATUS_WIDTH-1:0] rsp_status_ff;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff;
   logic [LENGTH_WIDTH-1:0] min_length_ff;
   logic [LENGTH_WIDTH-1:0] max_length_ff;
   logic                    rsp_free;
   logic                    advance;

   // Handshake control.
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && rsp_free;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_LENGTH: min_length_ff <= csr_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_data_byte;
         in_no_byte_ff <= req_no_byte;
         in_last_ff    <= req_last;
      end
   end

   // Byte check and name state update.
   unlc_step u_step (
      .state_cur  (state_ff),
      .data_byte  (in_byte_ff),
      .no_byte    (in_no_byte_ff),
      .last       (in_last_ff),
      .min_length (min_length_ff),
      .max_length (max_length_ff),
      .state_next (state_in),
      .verdict    (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= advance && verdict.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && verdict.valid) begin
         rsp_status_ff <= verdict.status;
         rsp_count_ff  <= verdict.code_points;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_code_points = rsp_count_ff;

endmodule

>>> rtl/core/unlc_step.sv
module unlc_step (
   input  unlc_pkg::name_state_type             state_cur,
   input  logic [unlc_pkg::BYTE_WIDTH-1:0]      data_byte,
   input  logic                                 no_byte,
   input  logic                                 last,
   input  logic [unlc_pkg::LENGTH_WIDTH-1:0]    min_length,
   input  logic [unlc_pkg::LENGTH_WIDTH-1:0]    max_length,
   output unlc_pkg::name_state_type             state_next,
   output unlc_pkg::verdict_type                verdict
);
   import unlc_pkg::*;

   logic                   is_space;
   logic                   ascii_bad;
   logic [CODE_WIDTH-1:0]  acc_shifted;
   logic [CODE_WIDTH-1:0]  code_floor;
   logic                   code_bad;
   logic [COUNT_WIDTH:0]   pending_sum;
   logic [COUNT_WIDTH-1:0] merged_count;
   logic [COUNT_WIDTH-1:0] counted_one;
   logic [COUNT_WIDTH-1:0] final_count;
   name_state_type         upd;

   // Byte classes.
   assign is_space  = (data_byte == SPACE_CHAR) ||
                      ((data_byte >= TAB_CHAR) && (data_byte <= CR_CHAR));
   assign ascii_bad = (data_byte < SPACE_CHAR) || (data_byte == DEL_CHAR) ||
                      (data_byte == PIPE_CHAR) || (data_byte == PERCENT_CHAR);

   // Continuation byte folded into the code point, and its range checks.
   assign acc_shifted = {state_cur.code_accumulator[CODE_WIDTH-7:0], data_byte[5:0]};

   always_comb begin
      case (state_cur.sequence_length)
         2'd1:    code_floor = FLOOR_TWO_BYTE;
         2'd2:    code_floor = FLOOR_THREE_BYTE;
         default: code_floor = FLOOR_FOUR_BYTE;
      endcase
   end

   assign code_bad = (acc_shifted < code_floor) ||
                     ((acc_shifted >= SURROGATE_LOW) && (acc_shifted <= SURROGATE_HIGH)) ||
                     ((acc_shifted >= C1_LOW) && (acc_shifted <= C1_HIGH)) ||
                     (acc_shifted > CODE_MAX);

   // Held whitespace joins the count when text follows it.
   assign pending_sum = {1'b0, state_cur.point_count} + {1'b0, state_cur.pending_spaces};

   always_comb begin
      if (state_cur.seen_text && (state_cur.pending_spaces != '0)) begin
         if (pending_sum > {1'b0, COUNT_CAP}) begin
            merged_count = COUNT_CAP;
         end else begin
            merged_count = pending_sum[COUNT_WIDTH-1:0];
         end
      end else begin
         merged_count = state_cur.point_count;
      end
   end

   assign counted_one = (merged_count < COUNT_CAP) ? (merged_count + 1'b1) : merged_count;

   // Per-byte state update.
   always_comb begin
      upd = state_cur;
      if (!no_byte && !state_cur.bad_seen) begin
         if (is_space) begin
            if (state_cur.seen_text) begin
               if (state_cur.bytes_left != 2'd0) begin
                  upd.bad_seen = 1'b1;
               end else begin
                  if (data_byte != SPACE_CHAR) begin
                     upd.pending_has_control = 1'b1;
                  end
                  if (state_cur.pending_spaces < COUNT_CAP) begin
                     upd.pending_spaces = state_cur.pending_spaces + 1'b1;
                  end
               end
            end
         end else if (state_cur.seen_text && (state_cur.pending_spaces != '0) &&
                      state_cur.pending_has_control) begin
            upd.bad_seen = 1'b1;
         end else begin
            upd.point_count         = merged_count;
            upd.pending_spaces      = '0;
            upd.pending_has_control = 1'b0;
            upd.seen_text           = 1'b1;
            if (state_cur.bytes_left != 2'd0) begin
               if (data_byte[7:6] != 2'b10) begin
                  upd.bad_seen = 1'b1;
               end else begin
                  upd.code_accumulator = acc_shifted;
                  upd.bytes_left       = state_cur.bytes_left - 2'd1;
                  if (state_cur.bytes_left == 2'd1) begin
                     if (code_bad) begin
                        upd.bad_seen = 1'b1;
                     end else begin
                        upd.point_count = counted_one;
                     end
                  end
               end
            end else if (!data_byte[7]) begin
               if (ascii_bad) begin
                  upd.bad_seen = 1'b1;
               end else begin
                  upd.point_count = counted_one;
               end
            end else if (data_byte[7:5] == 3'b110) begin
               upd.sequence_length  = 2'd1;
               upd.bytes_left       = 2'd1;
               upd.code_accumulator = {16'd0, data_byte[4:0]};
            end else if (data_byte[7:4] == 4'b1110) begin
               upd.sequence_length  = 2'd2;
               upd.bytes_left       = 2'd2;
               upd.code_accumulator = {17'd0, data_byte[3:0]};
            end else if (data_byte[7:3] == 5'b11110) begin
               upd.sequence_length  = 2'd3;
               upd.bytes_left       = 2'd3;
               upd.code_accumulator = {18'd0, data_byte[2:0]};
            end else begin
               upd.bad_seen = 1'b1;
            end
         end
      end
   end

   // Verdict on the final request; the state starts over for the next name.
   assign final_count = upd.point_count;

   always_comb begin
      verdict.valid       = last;
      verdict.status      = STATUS_OK;
      verdict.code_points = final_count;
      if (upd.bad_seen || (upd.bytes_left != 2'd0)) begin
         verdict.status      = STATUS_INVALID;
         verdict.code_points = '0;
      end else if ((final_count == '0) || (final_count < {1'b0, min_length})) begin
         verdict.status = STATUS_TOO_SHORT;
      end else if (final_count > {1'b0, max_length}) begin
         verdict.status = STATUS_TOO_LONG;
      end
      state_next = last ? name_state_type'('0) : upd;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import unlc_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 6;

   // One request: a byte of the name, or an empty slot, plus the end marker.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data;
      logic                  no_byte;
      logic                  is_last;
   } name_request_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [COUNT_WIDTH-1:0]  code_points;
   } name_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [BYTE_WIDTH-1:0]      req_data_byte = '0;
   logic                       req_no_byte   = 1'b0;
   logic                       req_last      = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [STATUS_WIDTH-1:0]    rsp_status;
   logic [COUNT_WIDTH-1:0]     rsp_code_points;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [LENGTH_WIDTH-1:0]    csr_data      = '0;

   name_request_type  pending_q[$];
   name_verdict_type  verdict_q[$];
   logic [BYTE_WIDTH-1:0] text_q[$];

   // Shadow copy of the block's limits and running name state.
   logic [LENGTH_WIDTH-1:0] min_limit = MIN_LENGTH_RESET;
   logic [LENGTH_WIDTH-1:0] max_limit = MAX_LENGTH_RESET;
   name_state_type          name_st   = '0;

   bit idling_on     = 1'b1;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int req_gap       = 0;
   int rsp_gap       = 0;

   int mismatches     = 0;
   int requests_taken = 0;
   int verdicts_seen  = 0;
   int settings_used  = 0;
   int quiet_cycles   = 0;
   int status_hits[4] = '{0, 0, 0, 0};

   utf8_name_length_checker_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_no_byte     (req_no_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_code_points (rsp_code_points),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Prediction of the verdict for each name.
   // ---------------------------------------------------------------------

   function automatic bit is_blank(input logic [BYTE_WIDTH-1:0] b);
      return b == SPACE_CHAR || (b >= TAB_CHAR && b <= CR_CHAR);
   endfunction

   function automatic void bump_points();
      if (name_st.point_count < COUNT_CAP) begin
         name_st.point_count++;
      end
   endfunction

   // A multi-byte sequence is complete: reject overlong, surrogate, C1 and
   // out-of-range values, otherwise count one code point.
   function automatic void close_sequence();
      logic [CODE_WIDTH-1:0] cp;
      logic [CODE_WIDTH-1:0] floor_cp;
      cp = name_st.code_accumulator;
      floor_cp = (name_st.sequence_length == 2'd1) ? FLOOR_TWO_BYTE :
                 (name_st.sequence_length == 2'd2) ? FLOOR_THREE_BYTE : FLOOR_FOUR_BYTE;
      if (cp < floor_cp || (cp >= SURROGATE_LOW && cp <= SURROGATE_HIGH) ||
          (cp >= C1_LOW && cp <= C1_HIGH) || cp > CODE_MAX) begin
         name_st.bad_seen = 1'b1;
      end else begin
         bump_points();
      end
   endfunction

   function automatic void take_text_byte(input logic [BYTE_WIDTH-1:0] b);
      // Continuation of a sequence in progress.
      if (name_st.bytes_left != 2'd0) begin
         if (b[7:6] != 2'b10) begin
            name_st.bad_seen = 1'b1;
            return;
         end
         name_st.code_accumulator = {name_st.code_accumulator[CODE_WIDTH-7:0], b[5:0]};
         name_st.bytes_left--;
         if (name_st.bytes_left == 2'd0) begin
            close_sequence();
         end
         return;
      end
      // Plain ASCII, with controls and the reserved characters refused.
      if (b[7] == 1'b0) begin
         if (b < SPACE_CHAR || b == DEL_CHAR || b == PIPE_CHAR || b == PERCENT_CHAR) begin
            name_st.bad_seen = 1'b1;
         end else begin
            bump_points();
         end
         return;
      end
      // Lead bytes open a sequence; anything else is a stray byte.
      if (b[7:5] == 3'b110) begin
         name_st.sequence_length  = 2'd1;
         name_st.code_accumulator = CODE_WIDTH'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         name_st.sequence_length  = 2'd2;
         name_st.code_accumulator = CODE_WIDTH'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         name_st.sequence_length  = 2'd3;
         name_st.code_accumulator = CODE_WIDTH'(b[2:0]);
      end else begin
         name_st.bad_seen = 1'b1;
         return;
      end
      name_st.bytes_left = name_st.sequence_length;
   endfunction

   function automatic void take_name_byte(input logic [BYTE_WIDTH-1:0] b);
      int sum;
      if (name_st.bad_seen) begin
         return;
      end
      // Whitespace is dropped before text and held as pending after it.
      if (is_blank(b)) begin
         if (!name_st.seen_text) begin
            return;
         end
         if (name_st.bytes_left != 2'd0) begin
            name_st.bad_seen = 1'b1;
            return;
         end
         if (b != SPACE_CHAR) begin
            name_st.pending_has_control = 1'b1;
         end
         if (name_st.pending_spaces < COUNT_CAP) begin
            name_st.pending_spaces++;
         end
         return;
      end
      // Text after a held run makes that run part of the name.
      if (name_st.seen_text && name_st.pending_spaces != '0) begin
         if (name_st.pending_has_control) begin
            name_st.bad_seen = 1'b1;
            return;
         end
         sum = int'(name_st.point_count) + int'(name_st.pending_spaces);
         name_st.point_count = (sum > int'(COUNT_CAP)) ? COUNT_CAP : COUNT_WIDTH'(sum);
      end
      name_st.pending_spaces      = '0;
      name_st.pending_has_control = 1'b0;
      name_st.seen_text           = 1'b1;
      take_text_byte(b);
   endfunction

   function automatic void predict_request(input name_request_type r);
      name_verdict_type v;
      if (!r.no_byte) begin
         take_name_byte(r.data);
      end
      if (r.is_last) begin
         if (name_st.bad_seen || name_st.bytes_left != 2'd0) begin
            v.status      = STATUS_INVALID;
            v.code_points = '0;
         end else begin
            v.code_points = name_st.point_count;
            if (name_st.point_count == '0 || name_st.point_count < min_limit) begin
               v.status = STATUS_TOO_SHORT;
            end else if (name_st.point_count > max_limit) begin
               v.status = STATUS_TOO_LONG;
            end else begin
               v.status = STATUS_OK;
            end
         end
         verdict_q.insert(verdict_q.size(), v);
         name_st = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic             drive_next;
      name_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_next = 1'b0;
         if (req_valid && req_ready) begin
            predict_request('{req_data_byte, req_no_byte, req_last});
            requests_taken++;
         end else if (req_valid) begin
            drive_next = 1'b1;
         end
         if (!drive_next) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_q.size() != 0) begin
               if (idling_on && $urandom_range(0, 99) < req_gap_pct) begin
                  req_gap = $urandom_range(0, 11);
               end else begin
                  item = pending_q.pop_front();
                  req_data_byte <= item.data;
                  req_no_byte   <= item.no_byte;
                  req_last      <= item.is_last;
                  drive_next    = 1'b1;
               end
            end
         end
         req_valid <= drive_next;
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor with random receiver stalls.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_verdicts
      name_verdict_type want;
      logic             ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
               report_mismatch("response with no name pending", rsp_status, -1);
            end else begin
               want = verdict_q.pop_front();
               status_hits[want.status]++;
               if (rsp_status !== want.status) begin
                  report_mismatch("status", rsp_status, want.status);
               end
               if (rsp_code_points !== want.code_points) begin
                  report_mismatch("code point count", rsp_code_points, want.code_points);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            ready_next = 1'b0;
         end else if (idling_on && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_gap    = $urandom_range(0, 11);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog: the run ends if no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
                  quiet_cycles, verdict_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------

   function automatic void push_req(input logic [BYTE_WIDTH-1:0] b, input logic nb,
                                    input logic lst);
      name_request_type r;
      r.data    = b;
      r.no_byte = nb;
      r.is_last = lst;
      pending_q.insert(pending_q.size(), r);
   endfunction

   // Appends one byte to the name under construction.
   function automatic void add_text(input logic [BYTE_WIDTH-1:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] pick_blank();
      if ($urandom_range(0, 3) == 0) begin
         return BYTE_WIDTH'($urandom_range(TAB_CHAR, CR_CHAR));
      end
      return SPACE_CHAR;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   function automatic void append_code_point(input logic [CODE_WIDTH-1:0] cp);
      if (cp < FLOOR_TWO_BYTE) begin
         add_text(cp[7:0]);
      end else if (cp < FLOOR_THREE_BYTE) begin
         add_text({3'b110, cp[10:6]});
         add_text({2'b10, cp[5:0]});
      end else if (cp < FLOOR_FOUR_BYTE) begin
         add_text({4'b1110, cp[15:12]});
         add_text({2'b10, cp[11:6]});
         add_text({2'b10, cp[5:0]});
      end else begin
         add_text({5'b11110, cp[20:18]});
         add_text({2'b10, cp[17:12]});
         add_text({2'b10, cp[11:6]});
         add_text({2'b10, cp[5:0]});
      end
   endfunction

   // A legal code point, weighted toward ASCII, with the encoding edges mixed in.
   function automatic logic [CODE_WIDTH-1:0] random_code_point();
      logic [CODE_WIDTH-1:0] cp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            do cp = CODE_WIDTH'($urandom_range(8'h21, 8'h7E));
            while (cp == CODE_WIDTH'(PIPE_CHAR) || cp == CODE_WIDTH'(PERCENT_CHAR));
         end
         5: cp = CODE_WIDTH'($urandom_range(21'hA0, 21'h7FF));
         6: begin
            do cp = CODE_WIDTH'($urandom_range(21'h800, 21'hFFFF));
            while (cp >= SURROGATE_LOW && cp <= SURROGATE_HIGH);
         end
         7: cp = CODE_WIDTH'($urandom_range(21'h10000, 21'h10FFFF));
         default: begin
            case ($urandom_range(0, 7))
               0: cp = 21'hA0;
               1: cp = 21'h7FF;
               2: cp = 21'h800;
               3: cp = 21'hD7FF;
               4: cp = 21'hE000;
               5: cp = 21'hFFFF;
               6: cp = 21'h10000;
               default: cp = CODE_MAX;
            endcase
         end
      endcase
      return cp;
   endfunction

   // One malformed or refused fragment of the kinds the checker must catch.
   function automatic void append_defect();
      case ($urandom_range(0, 12))
         0: begin
            case ($urandom_range(0, 4))
               0: add_text(BYTE_WIDTH'($urandom_range(8'h00, 8'h08)));
               1: add_text(BYTE_WIDTH'($urandom_range(8'h0E, 8'h1F)));
               2: add_text(DEL_CHAR);
               3: add_text(PIPE_CHAR);
               default: add_text(PERCENT_CHAR);
            endcase
         end
         1: begin
            // C1 control in two-byte form.
            add_text(8'hC2);
            add_text(BYTE_WIDTH'($urandom_range(8'h80, 8'h9F)));
         end
         2: begin
            // Encoded surrogate.
            add_text(8'hED);
            add_text(BYTE_WIDTH'($urandom_range(8'hA0, 8'hBF)));
            add_text(cont_byte());
         end
         3: begin
            add_text(BYTE_WIDTH'($urandom_range(8'hC0, 8'hC1)));
            add_text(cont_byte());
         end
         4: begin
            add_text(8'hE0);
            add_text(BYTE_WIDTH'($urandom_range(8'h80, 8'h9F)));
            add_text(cont_byte());
         end
         5: begin
            add_text(8'hF0);
            add_text(BYTE_WIDTH'($urandom_range(8'h80, 8'h8F)));
            add_text(cont_byte());
            add_text(cont_byte());
         end
         6: begin
            // Just above the last code point.
            add_text(8'hF4);
            add_text(BYTE_WIDTH'($urandom_range(8'h90, 8'hBF)));
            add_text(cont_byte());
            add_text(cont_byte());
         end
         7: begin
            add_text(BYTE_WIDTH'($urandom_range(8'hF5, 8'hF7)));
            repeat (3) add_text(cont_byte());
         end
         8: add_text(cont_byte());
         9: add_text(BYTE_WIDTH'($urandom_range(8'hF8, 8'hFF)));
         10: begin
            // Sequence cut short by a plain character.
            add_text(8'hE1);
            add_text(cont_byte());
            add_text("x");
         end
         11: add_text(BYTE_WIDTH'($urandom_range(TAB_CHAR, CR_CHAR)));
         default: begin
            add_text(8'hC3);
            add_text(pick_blank());
            add_text(8'hA9);
         end
      endcase
   endfunction

   // Turns the bytes in text_q into requests, with empty slots sprinkled in
   // and sometimes an empty request closing the name. Returns the count of
   // requests that carry a byte or end the name.
   function automatic int queue_name_requests();
      bit empty_tail;
      int cost;
      empty_tail = text_q.size() == 0 || $urandom_range(0, 4) == 0;
      cost = 0;
      foreach (text_q[i]) begin
         if ($urandom_range(0, 19) == 0) begin
            push_req(BYTE_WIDTH'($urandom), 1'b1, 1'b0);
         end
         push_req(text_q[i], 1'b0, !empty_tail && i == text_q.size() - 1);
         cost++;
      end
      if (empty_tail) begin
         push_req(BYTE_WIDTH'($urandom), 1'b1, 1'b1);
         cost++;
      end
      return cost;
   endfunction

   // Mostly well-formed names, some with one defect, a few of raw noise.
   function automatic int queue_random_name();
      int kind;
      int n;
      int defect_at;
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         repeat ($urandom_range(1, 10)) add_text(BYTE_WIDTH'($urandom));
      end else begin
         repeat ($urandom_range(0, 2)) add_text(pick_blank());
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 14);
         defect_at = (kind >= 70) ? $urandom_range(0, n) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == defect_at) begin
               append_defect();
            end
            if (i > 0 && $urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 2)) add_text(SPACE_CHAR);
            end
            append_code_point(random_code_point());
         end
         if (defect_at == n) begin
            append_defect();
         end
         repeat ($urandom_range(0, 3)) add_text(pick_blank());
      end
      return queue_name_requests();
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 50;
      endcase
   endfunction

   // Waits until every request is taken and every verdict has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_length_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                   input logic [LENGTH_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MIN_LENGTH) begin
         min_limit = value;
      end else begin
         max_limit = value;
      end
   endtask

   task automatic run_phase(input logic [LENGTH_WIDTH-1:0] lo,
                            input logic [LENGTH_WIDTH-1:0] hi, input int budget);
      int spent;
      write_length_reg(CSR_MIN_LENGTH, lo);
      write_length_reg(CSR_MAX_LENGTH, hi);
      settings_used++;
      req_gap_pct   = pick_pct();
      rsp_stall_pct = pick_pct();
      spent = 0;
      while (spent < budget) begin
         spent += queue_random_name();
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin : run_test
      logic [LENGTH_WIDTH-1:0] lo_pick;
      logic [LENGTH_WIDTH-1:0] hi_pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;
      req_gap_pct   = 20;
      rsp_stall_pct = 20;

      // Directed names under the reset limits.
      // Empty name, closed by a request without a byte.
      push_req(8'h00, 1'b1, 1'b1);
      // Whitespace only.
      push_req(SPACE_CHAR, 1'b0, 1'b0);
      push_req(CR_CHAR, 1'b0, 1'b1);
      // Interior space counts; an empty slot in the middle does nothing.
      push_req(SPACE_CHAR, 1'b0, 1'b0);
      push_req("a", 1'b0, 1'b0);
      push_req(SPACE_CHAR, 1'b0, 1'b0);
      push_req(8'hFF, 1'b1, 1'b0);
      push_req("b", 1'b0, 1'b0);
      push_req(SPACE_CHAR, 1'b0, 1'b1);
      // Interior tab once text follows it.
      push_req("a", 1'b0, 1'b0);
      push_req(TAB_CHAR, 1'b0, 1'b0);
      push_req("b", 1'b0, 1'b1);
      // Trailing control whitespace is simply trimmed.
      push_req("a", 1'b0, 1'b0);
      push_req(8'h0B, 1'b0, 1'b1);
      // Whitespace inside a two-byte sequence.
      push_req(8'hC3, 1'b0, 1'b0);
      push_req(SPACE_CHAR, 1'b0, 1'b0);
      push_req(8'hA9, 1'b0, 1'b1);
      // Stray continuation, then a valid byte that must be ignored.
      push_req(8'h80, 1'b0, 1'b0);
      push_req("a", 1'b0, 1'b1);
      // Lead byte that can never start a sequence.
      push_req(8'hFF, 1'b0, 1'b1);
      // Four-byte lead beyond the code space.
      push_req(8'hF5, 1'b0, 1'b0);
      push_req(8'h80, 1'b0, 1'b0);
      push_req(8'h80, 1'b0, 1'b0);
      push_req(8'h80, 1'b0, 1'b1);
      // Name ends inside a three-byte sequence.
      push_req(8'hE2, 1'b0, 1'b0);
      push_req(8'h82, 1'b0, 1'b1);
      // NUL byte.
      push_req(8'h00, 1'b0, 1'b1);
      wait_idle();

      // Limit extremes, including a minimum above the maximum.
      run_phase(10'd0, 10'd1023, 100);
      run_phase(10'd1023, 10'd0, 80);
      run_phase(10'd0, 10'd0, 80);

      // Saturation: a long interior space run pushes both counters to the cap.
      write_length_reg(CSR_MIN_LENGTH, 10'd1023);
      write_length_reg(CSR_MAX_LENGTH, 10'd1023);
      settings_used++;
      push_req("a", 1'b0, 1'b0);
      repeat (1026) push_req(SPACE_CHAR, 1'b0, 1'b0);
      push_req("b", 1'b0, 1'b0);
      push_req("c", 1'b0, 1'b1);
      wait_idle();

      // Random limits, mostly in the range that short names reach.
      repeat (5) begin
         lo_pick = LENGTH_WIDTH'($urandom_range(0, 6));
         hi_pick = ($urandom_range(0, 3) == 0) ? LENGTH_WIDTH'($urandom_range(0, 1023))
                                                : LENGTH_WIDTH'($urandom_range(0, 20));
         run_phase(lo_pick, hi_pick, 60);
      end

      // Closing stretch at full rate on both sides.
      idling_on = 1'b0;
      lo_pick = LENGTH_WIDTH'($urandom_range(1, 4));
      hi_pick = LENGTH_WIDTH'($urandom_range(6, 20));
      run_phase(lo_pick, hi_pick, 150);

      $display("Checked %0d names from %0d requests under %0d length settings.",
               verdicts_seen, requests_taken, settings_used);
      $display("Verdicts: %0d ok, %0d too short, %0d too long, %0d invalid.",
               status_hits[STATUS_OK], status_hits[STATUS_TOO_SHORT],
               status_hits[STATUS_TOO_LONG], status_hits[STATUS_INVALID]);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
